// ===== hw/rtl/palette_fade_engine_top_defines.svh =====
// Assertion macros for the palette fade engine top-level RTL.
`ifndef PALETTE_FADE_ENGINE_TOP_DEFINES_SVH
`define PALETTE_FADE_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only while reset is released.
`define PFE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("palette fade engine: assertion failed");
// Checked at every clock edge, reset included.
`define PFE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("palette fade engine: assertion failed");
`else
`define PFE_ASSERT(lbl, prop)
`define PFE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hw/rtl/pfe_pkg.sv =====
`timescale 1ns / 1ps
package pfe_pkg;

  localparam int PALETTE_BYTES_DEF = 768;
  localparam int FADE_STEPS_DEF    = 32;

  localparam int LEVEL_W = 6;
  localparam int IDX_W   = 10;
  localparam int FRAME_W = 6;
  localparam int ACC_W   = 14;
  localparam int STEP_W  = 16;
  localparam int MEM_W   = STEP_W + ACC_W;
  localparam int FRAC_W  = 8;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL = 6'd63;
  localparam logic [ACC_W-1:0]   ACC_MAX   = 14'h3fff;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } pfe_state_t;

endpackage

// ===== hw/rtl/pfe_ram.sv =====
`timescale 1ns / 1ps
module pfe_ram #(
  parameter int DEPTH  = pfe_pkg::PALETTE_BYTES_DEF,
  parameter int WIDTH  = pfe_pkg::MEM_W,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a stalled consumer keeps it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/pfe_step_calc.sv =====
`timescale 1ns / 1ps
module pfe_step_calc #(
  parameter int FADE_STEPS = pfe_pkg::FADE_STEPS_DEF
) (
  input  logic                               fade_in,
  input  logic        [pfe_pkg::LEVEL_W-1:0] level,
  output logic signed [pfe_pkg::STEP_W-1:0]  step
);

  // Division by FADE_STEPS as a multiply by a rounded-up reciprocal. With
  // RECIP_SHIFT = numerator bits + 6 the quotient is exact for FADE_STEPS < 64.
  localparam int RECIP_SHIFT = pfe_pkg::ACC_W + 6;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = pfe_pkg::ACC_W + RECIP_W;
  localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + FADE_STEPS - 1) / FADE_STEPS;

  logic [pfe_pkg::LEVEL_W-1:0] dist_lvl;
  logic [pfe_pkg::ACC_W-1:0]   numer;
  logic [PROD_W-1:0]           prod;
  logic [pfe_pkg::ACC_W-1:0]   quot;
  logic [pfe_pkg::STEP_W-1:0]  mag;

  always_comb begin
    dist_lvl = fade_in ? (pfe_pkg::MAX_LEVEL - level) : level;
    numer    = {dist_lvl, {pfe_pkg::FRAC_W{1'b0}}};
    prod     = PROD_W'(numer) * PROD_W'(RECIP);
    quot     = prod[RECIP_SHIFT +: pfe_pkg::ACC_W];
    mag      = pfe_pkg::STEP_W'(quot);
    step     = fade_in ? $signed(mag) : $signed(~mag + 1'b1);
  end

endmodule

// ===== hw/rtl/palette_fade_engine_top.sv =====
`timescale 1ns / 1ps
// Channel  Direction  tdata (low bit up)                        tuser        tlast
// in_      slave      color[5:0], zero pad to 8 bits            cmd          -
// out_     master     level[5:0], entry_index[15:6],            fade_done    frame_end
//                     frame_number[21:16], zero pad to 24 bits
// cfg_     slave      cfg_data: fade_in, single register         -            -
//
// Each item is accepted in ST_IDLE and finished in ST_EXEC. An emit's accept cycle issues
// the palette memory read; in ST_EXEC a load writes its entry and a fading emit writes the
// modified entry back, both through the single write port. An emit stays in ST_EXEC while
// the output register still holds an untaken result; loads never wait on the output side.
// Reset clears pointers, frame counter and fade_in; the palette memory is not
// cleared, so entries must be loaded before they are emitted.
`include "palette_fade_engine_top_defines.svh"
module palette_fade_engine_top #(
  parameter int PALETTE_BYTES = pfe_pkg::PALETTE_BYTES_DEF,
  parameter int FADE_STEPS    = pfe_pkg::FADE_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // color[5:0], pad[7:6]
  input  logic [0:0]  in_tuser,   // cmd[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // level[5:0], entry_index[15:6], frame_number[21:16], pad
  output logic [0:0]  out_tuser,  // fade_done[0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data    // fade_in[0]
);

  localparam int ADDR_W  = $clog2(PALETTE_BYTES);
  localparam int LEVEL_W = pfe_pkg::LEVEL_W;
  localparam int FRAME_W = pfe_pkg::FRAME_W;
  localparam int ACC_W   = pfe_pkg::ACC_W;
  localparam int STEP_W  = pfe_pkg::STEP_W;
  localparam int MEM_W   = pfe_pkg::MEM_W;
  localparam int SUM_W   = STEP_W + 1;

  localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(PALETTE_BYTES - 1);
  localparam logic [FRAME_W-1:0] STEPS_CODE = FRAME_W'(FADE_STEPS);

  pfe_pkg::pfe_state_t state_r, state_nxt;

  logic               fade_in_r;
  logic [ADDR_W-1:0]  load_ptr_r, load_ptr_nxt;
  logic [ADDR_W-1:0]  emit_ptr_r, emit_ptr_nxt;
  logic [FRAME_W-1:0] frame_cnt_r, frame_cnt_nxt;

  // Per-item context captured at accept.
  logic               op_emit_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [LEVEL_W-1:0] color_r;
  logic               last_r;
  logic               fading_r;
  logic [FRAME_W-1:0] frame_r;

  logic               out_valid_r, out_valid_nxt;
  logic [23:0]        out_data_r;
  logic               out_last_r;
  logic               out_done_r;

  logic               in_accept;
  logic               cmd;
  logic [LEVEL_W-1:0] in_color;
  logic               emit_last;
  logic               emit_fading;

  logic               mem_we;
  logic [MEM_W-1:0]   mem_wdata;
  logic [MEM_W-1:0]   mem_rdata;
  logic               mem_re;

  logic signed [STEP_W-1:0] load_step;
  logic signed [STEP_W-1:0] rd_step;
  logic [ACC_W-1:0]         rd_acc;
  logic signed [SUM_W-1:0]  sum;
  logic [ACC_W-1:0]         acc_sat;
  logic [LEVEL_W-1:0]       out_level;
  logic                     emit_done;

  assign cmd         = in_tuser[0];
  assign in_color    = in_tdata[LEVEL_W-1:0];
  assign in_tready   = (state_r == pfe_pkg::ST_IDLE);
  assign in_accept   = in_tvalid && in_tready;
  assign emit_last   = (emit_ptr_r == LAST_ADDR);
  assign emit_fading = (frame_cnt_r < STEPS_CODE);
  assign mem_re      = in_accept && (cmd == pfe_pkg::CMD_EMIT);
  assign cfg_ready   = 1'b1;

  pfe_step_calc #(
    .FADE_STEPS(FADE_STEPS)
  ) u_step_calc (
    .fade_in(fade_in_r),
    .level  (color_r),
    .step   (load_step)
  );

  pfe_ram #(
    .DEPTH (PALETTE_BYTES),
    .WIDTH (MEM_W),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(addr_r),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(emit_ptr_r),
    .rd_data(mem_rdata)
  );

  // Add the step to the 6.8 accumulator, clamp to its range, and pick the output level.
  always_comb begin
    rd_acc  = mem_rdata[ACC_W-1:0];
    rd_step = $signed(mem_rdata[MEM_W-1:ACC_W]);
    sum     = $signed(SUM_W'(rd_acc)) + $signed({rd_step[STEP_W-1], rd_step});
    if (sum < 0) begin
      acc_sat = '0;
    end else if (sum > $signed(SUM_W'(pfe_pkg::ACC_MAX))) begin
      acc_sat = pfe_pkg::ACC_MAX;
    end else begin
      acc_sat = sum[ACC_W-1:0];
    end
    if (fading_r) begin
      out_level = acc_sat[ACC_W-1:ACC_W-LEVEL_W];
    end else begin
      out_level = fade_in_r ? pfe_pkg::MAX_LEVEL : '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    load_ptr_nxt  = load_ptr_r;
    emit_ptr_nxt  = emit_ptr_r;
    frame_cnt_nxt = frame_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    mem_wdata     = {rd_step, acc_sat};
    emit_done     = 1'b0;
    case (state_r)
      pfe_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = pfe_pkg::ST_EXEC;
          if (cmd == pfe_pkg::CMD_LOAD) begin
            load_ptr_nxt = (load_ptr_r == LAST_ADDR) ? '0 : load_ptr_r + 1'b1;
            // A load at the palette start restarts the fade.
            if (load_ptr_r == '0) begin
              frame_cnt_nxt = '0;
              emit_ptr_nxt  = '0;
            end
          end else begin
            emit_ptr_nxt = emit_last ? '0 : emit_ptr_r + 1'b1;
            if (!emit_fading) begin
              frame_cnt_nxt = STEPS_CODE;
            end else if (emit_last) begin
              frame_cnt_nxt = frame_cnt_r + 1'b1;
            end
          end
        end
      end
      pfe_pkg::ST_EXEC: begin
        if (!op_emit_r) begin
          mem_we    = 1'b1;
          mem_wdata = {load_step, color_r, {pfe_pkg::FRAC_W{1'b0}}};
          state_nxt = pfe_pkg::ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          mem_we        = fading_r;
          emit_done     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = pfe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfe_pkg::ST_IDLE;
      fade_in_r   <= 1'b0;
      load_ptr_r  <= '0;
      emit_ptr_r  <= '0;
      frame_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_ptr_r  <= load_ptr_nxt;
      emit_ptr_r  <= emit_ptr_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        fade_in_r <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_emit_r <= (cmd == pfe_pkg::CMD_EMIT);
      color_r   <= in_color;
      addr_r    <= (cmd == pfe_pkg::CMD_EMIT) ? emit_ptr_r : load_ptr_r;
      last_r    <= emit_last;
      fading_r  <= emit_fading;
      frame_r   <= emit_fading ? frame_cnt_r : STEPS_CODE;
    end
    if (emit_done) begin
      out_data_r <= {2'b00, frame_r, pfe_pkg::IDX_W'(addr_r), out_level};
      out_last_r <= last_r;
      out_done_r <= last_r && !fading_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_done_r;

  `PFE_ASSERT(a_done_on_frame_end, (out_tvalid && out_tuser[0]) |-> out_tlast)
  `PFE_ASSERT(a_frame_in_range, frame_cnt_r <= STEPS_CODE)
  `PFE_ASSERT(a_ptrs_in_range, (emit_ptr_r <= LAST_ADDR) && (load_ptr_r <= LAST_ADDR))
  `PFE_ASSERT(a_stalled_emit_waits,
      (state_r == pfe_pkg::ST_EXEC && op_emit_r && out_valid_r && !out_tready)
      |=> (state_r == pfe_pkg::ST_EXEC && $stable(out_tdata)))
  `PFE_ASSERT_ALWAYS(a_no_write_when_idle, (state_r == pfe_pkg::ST_IDLE) |-> !mem_we)

endmodule

// ===== dv/palette_fade_engine_top_test.sv =====
`timescale 1ns / 1ps
module palette_fade_engine_top_test;

  localparam int PALETTE_BYTES = pfe_pkg::PALETTE_BYTES_DEF;
  localparam int FADE_STEPS    = pfe_pkg::FADE_STEPS_DEF;
  localparam int QUIET_LIMIT   = 2000;

  typedef struct packed {
    logic [pfe_pkg::LEVEL_W-1:0] level;
    logic [pfe_pkg::IDX_W-1:0]   entry_index;
    logic [pfe_pkg::FRAME_W-1:0] frame_number;
    logic                        frame_end;
    logic                        fade_done;
  } faded_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_data = '0;

  // Shadow copy of the fade engine state.
  int          fade_acc [PALETTE_BYTES];
  int          fade_step [PALETTE_BYTES];
  bit          entry_loaded [PALETTE_BYTES];
  int unsigned load_ptr = 0;
  int unsigned emit_ptr = 0;
  int unsigned frame_cnt = 0;
  logic        fade_in_reg = 1'b0;

  faded_byte_t pending_bytes[$];
  int          mismatch_count = 0;
  bit          gaps_on = 1'b1;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  palette_fade_engine_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // color[5:0], pad[7:6]
    .in_tuser   (in_tuser),   // cmd[0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // level[5:0], entry_index[15:6], frame_number[21:16], pad
    .out_tuser  (out_tuser),  // fade_done[0]
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)    // fade_in[0]
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void fade_predict(logic cmd, logic [5:0] color);
    int unsigned p;
    int unsigned e;
    int          sum;
    faded_byte_t fb;
    if (cmd == pfe_pkg::CMD_LOAD) begin
      p = load_ptr;
      // Loading the first entry restarts the whole fade.
      if (p == 0) begin
        frame_cnt = 0;
        emit_ptr = 0;
      end
      fade_acc[p] = int'(color) * 256;
      if (fade_in_reg) begin
        fade_step[p] = ((int'(pfe_pkg::MAX_LEVEL) - int'(color)) * 256) / FADE_STEPS;
      end else begin
        fade_step[p] = -((int'(color) * 256) / FADE_STEPS);
      end
      entry_loaded[p] = 1'b1;
      load_ptr = (p + 1 == PALETTE_BYTES) ? 0 : p + 1;
    end else begin
      e = emit_ptr;
      fb.entry_index = e[pfe_pkg::IDX_W-1:0];
      fb.frame_end = (e == PALETTE_BYTES - 1);
      if (frame_cnt < FADE_STEPS) begin
        sum = fade_acc[e] + fade_step[e];
        if (sum < 0) sum = 0;
        if (sum > int'(pfe_pkg::ACC_MAX)) sum = int'(pfe_pkg::ACC_MAX);
        fade_acc[e] = sum;
        fb.level = sum[13:8];
        fb.frame_number = frame_cnt[pfe_pkg::FRAME_W-1:0];
        fb.fade_done = 1'b0;
        if (fb.frame_end) frame_cnt++;
      end else begin
        // The closing frame uses the direction in force right now.
        fb.level = fade_in_reg ? pfe_pkg::MAX_LEVEL : '0;
        fb.frame_number = pfe_pkg::FRAME_W'(FADE_STEPS);
        fb.fade_done = fb.frame_end;
        frame_cnt = FADE_STEPS;
      end
      emit_ptr = (e + 1 == PALETTE_BYTES) ? 0 : e + 1;
      pending_bytes.push_back(fb);
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_faded_byte();
    faded_byte_t want;
    if (pending_bytes.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual index %0d level %0d",
               $time, out_tdata[15:6], out_tdata[5:0]);
      mismatch_count++;
    end else begin
      want = pending_bytes.pop_front();
      check_field("level", want.level, out_tdata[5:0]);
      check_field("entry_index", want.entry_index, out_tdata[15:6]);
      check_field("frame_number", want.frame_number, out_tdata[21:16]);
      check_field("frame_end", want.frame_end, out_tlast);
      check_field("fade_done", want.fade_done, out_tuser[0]);
    end
  endfunction

  // Result side: check every transaction, then decide the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_faded_byte();
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_n && quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Leaves in_tvalid high after the transaction so back-to-back items need no toggle.
  task automatic send_item(input logic cmd, input logic [5:0] color);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {2'b00, color};
    do @(posedge clk); while (!in_tready);
    fade_predict(cmd, color);
  endtask

  // A load produces no result, so the task waits on past the empty queue to cover one still in flight.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fade_dir(input logic dir);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data <= dir;
    do @(posedge clk); while (!cfg_ready);
    fade_in_reg = dir;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_emit();
    send_item(pfe_pkg::CMD_EMIT, 6'($urandom_range(0, 63)));
  endtask

  task automatic test_config_and_first_frame();
    write_fade_dir(1'b1);
    write_fade_dir(1'b0);
    send_item(pfe_pkg::CMD_LOAD, 6'd0);
    send_item(pfe_pkg::CMD_LOAD, pfe_pkg::MAX_LEVEL);
    send_item(pfe_pkg::CMD_LOAD, 6'b101010);
    send_item(pfe_pkg::CMD_LOAD, 6'b010101);
    // The color field is ignored on an emit, so drive both extremes there.
    send_item(pfe_pkg::CMD_EMIT, 6'h3f);
    send_item(pfe_pkg::CMD_EMIT, 6'h00);
    send_emit();
    send_emit();
    write_fade_dir(1'b1);
    send_item(pfe_pkg::CMD_LOAD, 6'd0);
    send_item(pfe_pkg::CMD_LOAD, pfe_pkg::MAX_LEVEL);
    send_item(pfe_pkg::CMD_LOAD, 6'd30);
    send_emit();
    send_emit();
    send_emit();
    // Load one more entry and show it right away.
    send_item(pfe_pkg::CMD_LOAD, 6'd17);
    send_emit();
  endtask

  // Fills the rest of the palette, then emits past its end so the frame counter advances.
  task automatic test_frame_wrap();
    while (load_ptr != 0) send_item(pfe_pkg::CMD_LOAD, 6'($urandom_range(0, 63)));
    while (emit_ptr != 0) send_emit();
    repeat (160) send_emit();
  endtask

  // Phases of mixed loads and emits; each phase picks a direction and a load ratio.
  task automatic test_mixed_traffic();
    int sent;
    int phase_len;
    int load_odds;
    sent = 0;
    while (sent < 300) begin
      write_fade_dir(1'($urandom_range(0, 1)));
      phase_len = $urandom_range(50, 120);
      load_odds = $urandom_range(1, 8);
      repeat (phase_len) begin
        if ($urandom_range(0, 9) < load_odds || !entry_loaded[emit_ptr]) begin
          send_item(pfe_pkg::CMD_LOAD, 6'($urandom_range(0, 63)));
        end else begin
          send_emit();
        end
      end
      sent += phase_len;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_config_and_first_frame();
    test_mixed_traffic();
    gaps_on = 1'b0;
    test_frame_wrap();
    wait_for_drain();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
